@@ hw/rtl/sabu_pkg.sv @@
// ----------------------------------------------------------------------------
// sabu_pkg: shared types and constants of the scalar ALU and branch unit
// Operation codes, decoded micro-op fields and the queue entry layout.
// ----------------------------------------------------------------------------
package sabu_pkg;

  // Default depth of the decode-to-execute queue (range: 2 and up)
  localparam int unsigned QUEUE_DEPTH = 2;

  // Upper address bits kept by J and JAL
  localparam logic [31:0] SEGMENT_MASK = 32'hF000_0000;

  typedef enum logic [5:0] {
    CMD_ADDIU  = 6'd0,
    CMD_ADDU   = 6'd1,
    CMD_AND    = 6'd2,
    CMD_ANDI   = 6'd3,
    CMD_BEQ    = 6'd4,
    CMD_BGEZ   = 6'd5,
    CMD_BGEZAL = 6'd6,
    CMD_BGTZ   = 6'd7,
    CMD_BLEZ   = 6'd8,
    CMD_BLTZ   = 6'd9,
    CMD_BLTZAL = 6'd10,
    CMD_BNE    = 6'd11,
    CMD_BREAK  = 6'd12,
    CMD_J      = 6'd13,
    CMD_JAL    = 6'd14,
    CMD_JALR   = 6'd15,
    CMD_JR     = 6'd16,
    CMD_LUI    = 6'd17,
    CMD_NOR    = 6'd18,
    CMD_OR     = 6'd19,
    CMD_ORI    = 6'd20,
    CMD_SLL    = 6'd21,
    CMD_SLLV   = 6'd22,
    CMD_SLT    = 6'd23,
    CMD_SLTI   = 6'd24,
    CMD_SLTIU  = 6'd25,
    CMD_SLTU   = 6'd26,
    CMD_SRA    = 6'd27,
    CMD_SRAV   = 6'd28,
    CMD_SRL    = 6'd29,
    CMD_SRLV   = 6'd30,
    CMD_SUBU   = 6'd31,
    CMD_XOR    = 6'd32,
    CMD_XORI   = 6'd33
  } cmd_e;

  typedef enum logic [3:0] {
    ALU_NONE,
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR,
    ALU_XOR,
    ALU_NOR,
    ALU_SLT,
    ALU_SLTU,
    ALU_SLL,
    ALU_SRL,
    ALU_SRA,
    ALU_LUI,
    ALU_LINK
  } alu_op_e;

  typedef enum logic [1:0] {
    B_RT,
    B_SIMM,
    B_ZIMM
  } b_sel_e;

  typedef enum logic {
    SH_SA,
    SH_RS
  } sh_sel_e;

  typedef enum logic [3:0] {
    BR_NONE,
    BR_EQ,
    BR_NE,
    BR_GEZ,
    BR_GTZ,
    BR_LEZ,
    BR_LTZ,
    BR_JUMP,
    BR_REG
  } br_kind_e;

  typedef enum logic [1:0] {
    WT_NONE = 2'd0,
    WT_RD   = 2'd1,
    WT_RT   = 2'd2,
    WT_RA   = 2'd3
  } wt_e;

  // One decoded instruction with its operands, as held in the queue
  typedef struct packed {
    alu_op_e            alu_op;
    b_sel_e             b_sel;
    sh_sel_e            sh_sel;
    br_kind_e           br_kind;
    wt_e                wt;
    logic               halt;
    logic [31:0]        rs;
    logic [31:0]        rt;
    logic signed [15:0] imm;
    logic [4:0]         sa;
    logic [25:0]        jidx;
    logic [31:0]        pc;
  } uop_t;

endpackage

@@ hw/rtl/sabu_if.sv @@
// ----------------------------------------------------------------------------
// sabu_if: channel interfaces of the scalar ALU and branch unit
// Instruction, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sabu_item_if;
  logic               valid;
  logic               ready;
  logic [5:0]         command;
  logic [31:0]        rs_value;
  logic [31:0]        rt_value;
  logic signed [15:0] immediate;
  logic [4:0]         shift_amount;
  logic [25:0]        jump_index;
  logic [31:0]        program_counter;

  modport source (output valid, command, rs_value, rt_value, immediate,
                  shift_amount, jump_index, program_counter, input ready);
  modport sink (input valid, command, rs_value, rt_value, immediate,
                shift_amount, jump_index, program_counter, output ready);
endinterface

interface sabu_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  logic [1:0]  write_target;
  logic        branch_taken;
  logic [31:0] branch_target;
  logic        halt;
  logic        irq_raise;

  modport source (output valid, result, write_target, branch_taken,
                  branch_target, halt, irq_raise, input ready);
  modport sink (input valid, result, write_target, branch_taken,
                branch_target, halt, irq_raise, output ready);
endinterface

interface sabu_cfg_if;
  logic valid;
  logic ready;
  logic interrupt_on_break;

  modport source (output valid, interrupt_on_break, input ready);
  modport sink (input valid, interrupt_on_break, output ready);
endinterface

@@ hw/rtl/scalar_alu_branch_unit.sv @@
// ----------------------------------------------------------------------------
// scalar_alu_branch_unit: scalar integer ALU and branch unit
// Decoupled decode / execute pipeline for one 32-bit scalar instruction a beat.
// ----------------------------------------------------------------------------
// Usage:
//   item_i   carries one instruction a beat: command, rs_value, rt_value,
//            immediate, shift_amount, jump_index and program_counter.
//   result_o returns exactly one beat per instruction, in order: write-back
//            value, write slot, branch decision and target, halt and irq.
//   cfg_i    writes the interrupt_on_break bit; it is always ready, and the user
//            must write it only while the unit is idle, a rule left to the user.
// Timing: decode pushes into a QueueDepth-entry queue at the accepting edge;
//   the execute stage runs on the queue head and loads the result register,
//   so each instruction passes the queue and then the result register.
//   Throughput is one instruction per cycle while result_o is ready, set by the
//   combinational ALU and branch adder in the execute stage.
// Stall: while result_o is held off, the result register keeps its beat, the
//   queue fills, and item_i.ready drops once the queue is full; the next
//   instruction is still taken while a finished result waits.
// Reset: clears the queue, the result valid and interrupt_on_break.
// ----------------------------------------------------------------------------
module scalar_alu_branch_unit #(
  parameter int unsigned QueueDepth = sabu_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sabu_item_if.sink     item_i,
  sabu_result_if.source result_o,
  sabu_cfg_if.sink      cfg_i
);

  logic           irq_en_q;
  logic           push, full, pop, head_valid;
  sabu_pkg::uop_t push_uop, head_uop;

  // Configuration: single bit, taken on any valid beat
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_en_q <= 1'b0;
    end else if (cfg_i.valid) begin
      irq_en_q <= cfg_i.interrupt_on_break;
    end
  end

  // Front: accept and decode
  sabu_front u_front (
    .item_i (item_i),
    .full_i (full),
    .push_o (push),
    .uop_o  (push_uop)
  );

  // Queue between decode and execute
  sabu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .uop_i        (push_uop),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_uop)
  );

  // Back: execute and hold the result beat
  sabu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_uop),
    .pop_o        (pop),
    .irq_en_i     (irq_en_q),
    .result_o     (result_o)
  );

endmodule

@@ hw/rtl/sabu_front.sv @@
// ----------------------------------------------------------------------------
// sabu_front: instruction intake and decode
// Accepts instruction beats and turns each into a micro-op for the queue.
// ----------------------------------------------------------------------------
module sabu_front (
  sabu_item_if.sink    item_i,
  input  logic         full_i,
  output logic         push_o,
  output sabu_pkg::uop_t uop_o
);

  sabu_pkg::uop_t uop;

  always_comb begin
    uop         = '0;
    uop.alu_op  = sabu_pkg::ALU_NONE;
    uop.b_sel   = sabu_pkg::B_RT;
    uop.sh_sel  = sabu_pkg::SH_SA;
    uop.br_kind = sabu_pkg::BR_NONE;
    uop.wt      = sabu_pkg::WT_NONE;
    uop.halt    = 1'b0;
    uop.rs      = item_i.rs_value;
    uop.rt      = item_i.rt_value;
    uop.imm     = item_i.immediate;
    uop.sa      = item_i.shift_amount;
    uop.jidx    = item_i.jump_index;
    uop.pc      = item_i.program_counter;
    unique case (sabu_pkg::cmd_e'(item_i.command))
      sabu_pkg::CMD_ADDIU: begin
        uop.alu_op = sabu_pkg::ALU_ADD;  uop.b_sel = sabu_pkg::B_SIMM;
        uop.wt = sabu_pkg::WT_RT;
      end
      sabu_pkg::CMD_ADDU: begin
        uop.alu_op = sabu_pkg::ALU_ADD;  uop.wt = sabu_pkg::WT_RD;
      end
      sabu_pkg::CMD_AND: begin
        uop.alu_op = sabu_pkg::ALU_AND;  uop.wt = sabu_pkg::WT_RD;
      end
      sabu_pkg::CMD_ANDI: begin
        uop.alu_op = sabu_pkg::ALU_AND;  uop.b_sel = sabu_pkg::B_ZIMM;
        uop.wt = sabu_pkg::WT_RT;
      end
      sabu_pkg::CMD_BEQ:  uop.br_kind = sabu_pkg::BR_EQ;
      sabu_pkg::CMD_BGEZ: uop.br_kind = sabu_pkg::BR_GEZ;
      sabu_pkg::CMD_BGEZAL: begin
        uop.alu_op = sabu_pkg::ALU_LINK; uop.wt = sabu_pkg::WT_RA;
        uop.br_kind = sabu_pkg::BR_GEZ;
      end
      sabu_pkg::CMD_BGTZ: uop.br_kind = sabu_pkg::BR_GTZ;
      sabu_pkg::CMD_BLEZ: uop.br_kind = sabu_pkg::BR_LEZ;
      sabu_pkg::CMD_BLTZ: uop.br_kind = sabu_pkg::BR_LTZ;
      sabu_pkg::CMD_BLTZAL: begin
        uop.alu_op = sabu_pkg::ALU_LINK; uop.wt = sabu_pkg::WT_RA;
        uop.br_kind = sabu_pkg::BR_LTZ;
      end
      sabu_pkg::CMD_BNE:   uop.br_kind = sabu_pkg::BR_NE;
      sabu_pkg::CMD_BREAK: uop.halt = 1'b1;
      sabu_pkg::CMD_J:     uop.br_kind = sabu_pkg::BR_JUMP;
      sabu_pkg::CMD_JAL: begin
        uop.alu_op = sabu_pkg::ALU_LINK; uop.wt = sabu_pkg::WT_RA;
        uop.br_kind = sabu_pkg::BR_JUMP;
      end
      sabu_pkg::CMD_JALR: begin
        uop.alu_op = sabu_pkg::ALU_LINK; uop.wt = sabu_pkg::WT_RD;
        uop.br_kind = sabu_pkg::BR_REG;
      end
      sabu_pkg::CMD_JR: uop.br_kind = sabu_pkg::BR_REG;
      sabu_pkg::CMD_LUI: begin
        uop.alu_op = sabu_pkg::ALU_LUI;  uop.wt = sabu_pkg::WT_RT;
      end
      sabu_pkg::CMD_NOR: begin
        uop.alu_op = sabu_pkg::ALU_NOR;  uop.wt = sabu_pkg::WT_RD;
      end
      sabu_pkg::CMD_OR: begin
        uop.alu_op = sabu_pkg::ALU_OR;   uop.wt = sabu_pkg::WT_RD;
      end
      sabu_pkg::CMD_ORI: begin
        uop.alu_op = sabu_pkg::ALU_OR;   uop.b_sel = sabu_pkg::B_ZIMM;
        uop.wt = sabu_pkg::WT_RT;
      end
      sabu_pkg::CMD_SLL: begin
        uop.alu_op = sabu_pkg::ALU_SLL;  uop.wt = sabu_pkg::WT_RD;
      end
      sabu_pkg::CMD_SLLV: begin
        uop.alu_op = sabu_pkg::ALU_SLL;  uop.sh_sel = sabu_pkg::SH_RS;
        uop.wt = sabu_pkg::WT_RD;
      end
      sabu_pkg::CMD_SLT: begin
        uop.alu_op = sabu_pkg::ALU_SLT;  uop.wt = sabu_pkg::WT_RD;
      end
      sabu_pkg::CMD_SLTI: begin
        uop.alu_op = sabu_pkg::ALU_SLT;  uop.b_sel = sabu_pkg::B_SIMM;
        uop.wt = sabu_pkg::WT_RT;
      end
      sabu_pkg::CMD_SLTIU: begin
        uop.alu_op = sabu_pkg::ALU_SLTU; uop.b_sel = sabu_pkg::B_SIMM;
        uop.wt = sabu_pkg::WT_RT;
      end
      sabu_pkg::CMD_SLTU: begin
        uop.alu_op = sabu_pkg::ALU_SLTU; uop.wt = sabu_pkg::WT_RD;
      end
      sabu_pkg::CMD_SRA: begin
        uop.alu_op = sabu_pkg::ALU_SRA;  uop.wt = sabu_pkg::WT_RD;
      end
      sabu_pkg::CMD_SRAV: begin
        uop.alu_op = sabu_pkg::ALU_SRA;  uop.sh_sel = sabu_pkg::SH_RS;
        uop.wt = sabu_pkg::WT_RD;
      end
      sabu_pkg::CMD_SRL: begin
        uop.alu_op = sabu_pkg::ALU_SRL;  uop.wt = sabu_pkg::WT_RD;
      end
      sabu_pkg::CMD_SRLV: begin
        uop.alu_op = sabu_pkg::ALU_SRL;  uop.sh_sel = sabu_pkg::SH_RS;
        uop.wt = sabu_pkg::WT_RD;
      end
      sabu_pkg::CMD_SUBU: begin
        uop.alu_op = sabu_pkg::ALU_SUB;  uop.wt = sabu_pkg::WT_RD;
      end
      sabu_pkg::CMD_XOR: begin
        uop.alu_op = sabu_pkg::ALU_XOR;  uop.wt = sabu_pkg::WT_RD;
      end
      sabu_pkg::CMD_XORI: begin
        uop.alu_op = sabu_pkg::ALU_XOR;  uop.b_sel = sabu_pkg::B_ZIMM;
        uop.wt = sabu_pkg::WT_RT;
      end
      // undefined codes pass as a no-op whose result beat is all zero
      default: uop.alu_op = sabu_pkg::ALU_NONE;
    endcase
  end

  assign item_i.ready = !full_i;
  assign push_o       = item_i.valid && !full_i;
  assign uop_o        = uop;

endmodule

@@ hw/rtl/sabu_queue.sv @@
// ----------------------------------------------------------------------------
// sabu_queue: decoded micro-op queue
// Small circular buffer that decouples decode from execute.
// ----------------------------------------------------------------------------
module sabu_queue #(
  parameter int unsigned Depth = sabu_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sabu_pkg::uop_t uop_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output sabu_pkg::uop_t head_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  sabu_pkg::uop_t        entry_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= uop_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with unequal pointers");

endmodule

@@ hw/rtl/sabu_back.sv @@
// ----------------------------------------------------------------------------
// sabu_back: execute stage and result register
// Runs the ALU and branch logic on the queue head and holds the result beat.
// ----------------------------------------------------------------------------
module sabu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  sabu_pkg::uop_t head_i,
  output logic           pop_o,
  input  logic           irq_en_i,
  sabu_result_if.source  result_o
);

  sabu_pkg::uop_t u;
  logic [31:0] simm, zimm, opb, pc4, link, btarget, jtarget, tgt, res;
  logic [4:0]  sh;
  logic        taken, neg, zero;

  logic        out_valid_q;
  logic [31:0] result_q, target_q;
  logic [1:0]  wt_q;
  logic        taken_q, halt_q, irq_q;

  assign u    = head_i;
  assign simm = {{16{u.imm[15]}}, u.imm};
  assign zimm = {16'b0, u.imm};
  assign sh   = (u.sh_sel == sabu_pkg::SH_RS) ? u.rs[4:0] : u.sa;
  assign pc4  = u.pc + 32'd4;
  assign link = u.pc + 32'd8;
  assign btarget = pc4 + {simm[29:0], 2'b00};
  assign jtarget = (pc4 & sabu_pkg::SEGMENT_MASK) | {4'b0, u.jidx, 2'b00};
  assign neg  = u.rs[31];
  assign zero = (u.rs == '0);

  always_comb begin
    unique case (u.b_sel)
      sabu_pkg::B_SIMM: opb = simm;
      sabu_pkg::B_ZIMM: opb = zimm;
      default:          opb = u.rt;
    endcase
  end

  always_comb begin
    unique case (u.alu_op)
      sabu_pkg::ALU_ADD:  res = u.rs + opb;
      sabu_pkg::ALU_SUB:  res = u.rs - opb;
      sabu_pkg::ALU_AND:  res = u.rs & opb;
      sabu_pkg::ALU_OR:   res = u.rs | opb;
      sabu_pkg::ALU_XOR:  res = u.rs ^ opb;
      sabu_pkg::ALU_NOR:  res = ~(u.rs | opb);
      sabu_pkg::ALU_SLT:  res = {31'b0, $signed(u.rs) < $signed(opb)};
      sabu_pkg::ALU_SLTU: res = {31'b0, u.rs < opb};
      sabu_pkg::ALU_SLL:  res = u.rt << sh;
      sabu_pkg::ALU_SRL:  res = u.rt >> sh;
      sabu_pkg::ALU_SRA:  res = 32'($signed(u.rt) >>> sh);
      sabu_pkg::ALU_LUI:  res = {u.imm, 16'b0};
      sabu_pkg::ALU_LINK: res = link;
      default:            res = '0;
    endcase
  end

  always_comb begin
    taken = 1'b0;
    tgt   = btarget;
    unique case (u.br_kind)
      sabu_pkg::BR_EQ:   taken = (u.rs == u.rt);
      sabu_pkg::BR_NE:   taken = (u.rs != u.rt);
      sabu_pkg::BR_GEZ:  taken = !neg;
      sabu_pkg::BR_GTZ:  taken = !neg && !zero;
      sabu_pkg::BR_LEZ:  taken = neg || zero;
      sabu_pkg::BR_LTZ:  taken = neg;
      sabu_pkg::BR_JUMP: begin
        taken = 1'b1;
        tgt   = jtarget;
      end
      sabu_pkg::BR_REG: begin
        taken = 1'b1;
        tgt   = u.rs;
      end
      default:           taken = 1'b0;
    endcase
  end

  // advance when the result register is empty or being drained
  assign pop_o = head_valid_i && (!out_valid_q || result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      result_q <= res;
      wt_q     <= u.wt;
      taken_q  <= taken;
      target_q <= taken ? tgt : '0;
      halt_q   <= u.halt;
      irq_q    <= u.halt && irq_en_i;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.result        = result_q;
  assign result_o.write_target  = wt_q;
  assign result_o.branch_taken  = taken_q;
  assign result_o.branch_target = target_q;
  assign result_o.halt          = halt_q;
  assign result_o.irq_raise     = irq_q;

  a_nowrite_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && wt_q == sabu_pkg::WT_NONE) |-> result_q == '0)
    else $error("nonzero result without write target");

  a_target_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !taken_q) |-> target_q == '0)
    else $error("branch target set on untaken branch");

  a_irq_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && irq_q) |-> (halt_q && !taken_q))
    else $error("interrupt without halt");

endmodule
